// File: rtl/desc_pkg.sv
// ----------------------------------------------------------------------------
// desc_pkg
// Shared types and constants for the directed edge support counter.
// ----------------------------------------------------------------------------
package desc_pkg;

  localparam int VERTICES = 64;
  localparam int VTX_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int THR_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int ADDR_W   = $clog2(VERTICES);
  localparam int CNT_W    = $clog2(VERTICES + 1);

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_THR  = 2'd1;

  typedef struct packed {
    logic             action;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dst_vertex;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cycle_count;
    logic [COUNT_W-1:0] flow_count;
    logic               keep;
  } res_t;

  typedef struct packed {
    logic load;
    logic shift;
  } pc_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_COUNT,
    S_DONE
  } state_e;

endpackage

// File: rtl/directed_edge_support_counter.sv
// ----------------------------------------------------------------------------
// directed_edge_support_counter
// Directed graph store with bit-serial common out/in-neighbour counting.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An add request
// keeps busy high after acceptance through a row read, then a row write.
// A query keeps busy high through S_READ (row read), S_EVAL (load the
// counters), S_COUNT, in which the bit-serial counters shift through all
// VERTICES bits of the ANDed rows one bit a cycle, and S_DONE, in which
// res_valid_o strobes the result. The result is shown for that single cycle
// only and must be captured then; nothing can hold it off.
// Threshold writes are taken on the config channel at any time, but belong
// to periods when the block is idle. Both matrices read as empty after reset.
// ----------------------------------------------------------------------------
module directed_edge_support_counter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  desc_pkg::req_t                   req_i,
  output logic                             res_valid_o,
  output desc_pkg::res_t                   res_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [desc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [desc_pkg::THR_W-1:0]       cfg_data_i
);

  localparam int V  = desc_pkg::VERTICES;
  localparam int AW = desc_pkg::ADDR_W;

  desc_pkg::state_e state_q, state_d;
  desc_pkg::req_t   req_q;
  desc_pkg::pc_ctrl_t pc_ctrl;

  logic [desc_pkg::THR_W-1:0] cyc_thr_q, flw_thr_q;
  logic [AW-1:0] bit_cnt_q, bit_cnt_d;
  logic [V-1:0]  out_vld_q, out_vld_d, in_vld_q, in_vld_d;

  logic [AW-1:0] u_addr, v_addr;
  logic          u_ok, v_ok;
  logic [V-1:0]  out_rd_u, out_rd_v, in_rd_u, in_rd_v;
  logic [V-1:0]  out_row_u, out_row_v, in_row_u, in_row_v;
  logic          we;
  logic [V-1:0]  out_wdata, in_wdata;
  logic [desc_pkg::CNT_W-1:0] cyc_cnt, flw_cnt;

  assign u_addr = req_q.src_vertex[AW-1:0];
  assign v_addr = req_q.dst_vertex[AW-1:0];
  assign u_ok   = ({1'b0, req_q.src_vertex} < (desc_pkg::VTX_W + 1)'(V));
  assign v_ok   = ({1'b0, req_q.dst_vertex} < (desc_pkg::VTX_W + 1)'(V));

  // rows never written, or of an absent vertex, read as empty
  assign out_row_u = (u_ok && out_vld_q[u_addr]) ? out_rd_u : '0;
  assign out_row_v = (v_ok && out_vld_q[v_addr]) ? out_rd_v : '0;
  assign in_row_u  = (u_ok && in_vld_q[u_addr])  ? in_rd_u  : '0;
  assign in_row_v  = (v_ok && in_vld_q[v_addr])  ? in_rd_v  : '0;

  assign out_wdata = out_row_u | (V'(1) << v_addr);
  assign in_wdata  = in_row_v  | (V'(1) << u_addr);

  desc_ram #(.WIDTH(V), .DEPTH(V)) u_out_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (u_addr),
    .wdata_i   (out_wdata),
    .raddr_a_i (u_addr),
    .rdata_a_o (out_rd_u),
    .raddr_b_i (v_addr),
    .rdata_b_o (out_rd_v)
  );

  desc_ram #(.WIDTH(V), .DEPTH(V)) u_in_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (v_addr),
    .wdata_i   (in_wdata),
    .raddr_a_i (u_addr),
    .rdata_a_o (in_rd_u),
    .raddr_b_i (v_addr),
    .rdata_b_o (in_rd_v)
  );

  desc_popcnt u_cyc_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (pc_ctrl),
    .row_a_i (out_row_u),
    .row_b_i (out_row_v),
    .count_o (cyc_cnt)
  );

  desc_popcnt u_flw_cnt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (pc_ctrl),
    .row_a_i (in_row_u),
    .row_b_i (in_row_v),
    .count_o (flw_cnt)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      desc_pkg::S_IDLE:  if (start) state_d = desc_pkg::S_READ;
      desc_pkg::S_READ:  state_d = desc_pkg::S_EVAL;
      desc_pkg::S_EVAL: begin
        if (req_q.action == desc_pkg::ACT_QUERY) state_d = desc_pkg::S_COUNT;
        else state_d = desc_pkg::S_IDLE;
      end
      desc_pkg::S_COUNT: if (bit_cnt_q == '0) state_d = desc_pkg::S_DONE;
      desc_pkg::S_DONE:  state_d = desc_pkg::S_IDLE;
      default:           state_d = desc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy          = 1'b1;
    res_valid_o   = 1'b0;
    we            = 1'b0;
    pc_ctrl.load  = 1'b0;
    pc_ctrl.shift = 1'b0;
    case (state_q)
      desc_pkg::S_IDLE: busy = 1'b0;
      desc_pkg::S_READ: ;
      desc_pkg::S_EVAL: begin
        if (req_q.action == desc_pkg::ACT_QUERY) pc_ctrl.load = 1'b1;
        else we = u_ok && v_ok;
      end
      desc_pkg::S_COUNT: pc_ctrl.shift = 1'b1;
      desc_pkg::S_DONE:  res_valid_o = 1'b1;
      default:           busy = 1'b0;
    endcase
  end

  always_comb begin
    bit_cnt_d = bit_cnt_q;
    out_vld_d = out_vld_q;
    in_vld_d  = in_vld_q;
    if (pc_ctrl.load) begin
      bit_cnt_d = AW'(V - 1);
    end else if (pc_ctrl.shift) begin
      bit_cnt_d = bit_cnt_q - AW'(1);
    end
    if (we) begin
      out_vld_d[u_addr] = 1'b1;
      in_vld_d[v_addr]  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= desc_pkg::S_IDLE;
      bit_cnt_q <= '0;
      out_vld_q <= '0;
      in_vld_q  <= '0;
      cyc_thr_q <= '0;
      flw_thr_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      out_vld_q <= out_vld_d;
      in_vld_q  <= in_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == desc_pkg::CFG_CYCLE_THR) cyc_thr_q <= cfg_data_i;
        if (cfg_index_i == desc_pkg::CFG_FLOW_THR)  flw_thr_q <= cfg_data_i;
      end
    end
  end

  // hold the request for the whole operation
  always_ff @(posedge clk_i) begin
    if (start && !busy) req_q <= req_i;
  end

  assign cfg_ready_o = 1'b1;

  assign res_o.cycle_count = desc_pkg::COUNT_W'(cyc_cnt);
  assign res_o.flow_count  = desc_pkg::COUNT_W'(flw_cnt);
  assign res_o.keep        = (desc_pkg::COUNT_W'(cyc_cnt) >= cyc_thr_q) &&
                             (desc_pkg::COUNT_W'(flw_cnt) >= flw_thr_q);

endmodule

// File: rtl/desc_ram.sv
// ----------------------------------------------------------------------------
// desc_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module desc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/desc_popcnt.sv
// ----------------------------------------------------------------------------
// desc_popcnt
// Bit-serial common-neighbour counter: ANDs two rows into a shift register
// and counts the set bits one per cycle while shift is asserted.
// ----------------------------------------------------------------------------
module desc_popcnt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  desc_pkg::pc_ctrl_t           ctrl_i,
  input  logic [desc_pkg::VERTICES-1:0] row_a_i,
  input  logic [desc_pkg::VERTICES-1:0] row_b_i,
  output logic [desc_pkg::CNT_W-1:0]   count_o
);

  logic [desc_pkg::VERTICES-1:0] sr_q, sr_d;
  logic [desc_pkg::CNT_W-1:0]    cnt_q, cnt_d;

  always_comb begin
    sr_d  = sr_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      sr_d  = row_a_i & row_b_i;
      cnt_d = '0;
    end else if (ctrl_i.shift) begin
      cnt_d = cnt_q + desc_pkg::CNT_W'(sr_q[0]);
      sr_d  = sr_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign count_o = cnt_q;

endmodule

// File: rtl/desc_checker.sv
// ----------------------------------------------------------------------------
// desc_checker
// Port-level checks for the directed edge support counter, bound to the top.
// ----------------------------------------------------------------------------
module desc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic res_valid_o
);

  // a result only ends an accepted request
  a_res_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result strobe while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");

  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (!res_valid_o && !busy)) else $error("result not a single strobe");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy raised without a request");

endmodule

bind directed_edge_support_counter desc_checker u_desc_checker (.*);
